[rtl/ssp_pkg.sv]
`timescale 1ns / 1ps

package ssp_pkg;

	// default geometry of one register read
	localparam int ADDR_BITS_DEF = 9;
	localparam int DATA_BITS_DEF = 16;

	// sensor register addresses
	localparam logic [15:0] REG_ERR  = 16'd136;
	localparam logic [15:0] REG_TEMP = 16'd97;

	// configuration reset values
	localparam logic [15:0] HALF_PERIOD_RST = 16'd50;
	localparam logic [7:0]  TEMP_PERIOD_RST = 8'd16;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_HALF_PERIOD = 1'b0,
		CFG_TEMP_PERIOD = 1'b1
	} cfg_idx_t;

	// pin sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_SEL_HI  = 4'd1,
		PH_SEL_LO  = 4'd2,
		PH_ADDR_LO = 4'd3,
		PH_ADDR_HI = 4'd4,
		PH_TA_LO   = 4'd5,
		PH_TA_HI   = 4'd6,
		PH_TA_LO2  = 4'd7,
		PH_DAT_HI  = 4'd8,
		PH_DAT_LO  = 4'd9,
		PH_TAIL    = 4'd10
	} phase_t;

	// live configuration
	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [7:0]  temp_period_frames;
	} cfg_t;

	// one result per tick
	typedef struct packed {
		logic       frame_ignored;
		logic       status_update;
		logic [7:0] die_temperature;
		logic [1:0] blackcal_error;
		logic       busy_res;
		logic       mosi;
		logic       sck;
		logic       nss;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

[rtl/ssp_cfg.sv]
`timescale 1ns / 1ps

module ssp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [0:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output ssp_pkg::cfg_t     cfg
);

	logic [15:0] half_q;
	logic [7:0]  period_q;

	// register writes, one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= ssp_pkg::HALF_PERIOD_RST;
			period_q <= ssp_pkg::TEMP_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (ssp_pkg::cfg_idx_t'(cfg_index))
				ssp_pkg::CFG_HALF_PERIOD: half_q   <= cfg_data;
				ssp_pkg::CFG_TEMP_PERIOD: period_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.half_period_ticks  = half_q;
	assign cfg.temp_period_frames = period_q;

endmodule

[rtl/ssp_seq.sv]
`timescale 1ns / 1ps

module ssp_seq #(
	parameter int ADDR_BITS = ssp_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = ssp_pkg::DATA_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           cmd,
	input  logic           miso,
	input  ssp_pkg::cfg_t  cfg,
	output ssp_pkg::res_t  res
);

	localparam int MAXB   = (ADDR_BITS > DATA_BITS) ? ADDR_BITS : DATA_BITS;
	localparam int IDX_W  = (MAXB > 1) ? $clog2(MAXB) : 1;
	localparam int AIDX_W = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;
	localparam int DIDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [ADDR_BITS-1:0] ADDR_ERR  = ADDR_BITS'(ssp_pkg::REG_ERR);
	localparam logic [ADDR_BITS-1:0] ADDR_TEMP = ADDR_BITS'(ssp_pkg::REG_TEMP);
	localparam logic [IDX_W-1:0] ADDR_LAST = IDX_W'(ADDR_BITS - 1);
	localparam logic [IDX_W-1:0] DATA_LAST = IDX_W'(DATA_BITS - 1);

	ssp_pkg::phase_t        phase_q, phase_n, ent;
	logic [IDX_W-1:0]       bit_q, bit_n;
	logic [15:0]            wait_q, wait_n, half_eff;
	logic [DATA_BITS-1:0]   shift_q, shift_n;
	logic [31:0]            shift_ext;
	logic [7:0]             fc_q, fc_n;
	logic [8:0]             fc_inc;
	logic [7:0]             temp_q, temp_n;
	logic [1:0]             err_q, err_n, hold_q, hold_n;
	logic                   pend_q, pend_n, is_temp_q, is_temp_n;
	logic                   nss_q, nss_n, sck_q, sck_n, mosi_q, mosi_n;
	logic                   do_enter, ignored, upd;
	logic [ADDR_BITS-1:0]   addr_word;

	assign half_eff  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
	assign fc_inc    = {1'b0, fc_q} + 9'd1;
	assign shift_ext = 32'(shift_q);
	assign addr_word = is_temp_q ? ADDR_TEMP : ADDR_ERR;

	// next state of the pin sequencer for one tick
	always_comb begin
		phase_n   = phase_q;
		bit_n     = bit_q;
		wait_n    = wait_q;
		shift_n   = shift_q;
		fc_n      = fc_q;
		temp_n    = temp_q;
		err_n     = err_q;
		hold_n    = hold_q;
		pend_n    = pend_q;
		is_temp_n = is_temp_q;
		nss_n     = nss_q;
		sck_n     = sck_q;
		mosi_n    = mosi_q;
		do_enter  = 1'b0;
		ent       = phase_q;
		ignored   = 1'b0;
		upd       = 1'b0;

		if (phase_q == ssp_pkg::PH_IDLE) begin
			// frame request starts the error register read
			if (cmd) begin
				pend_n    = (fc_q == 8'd0);
				fc_n      = (fc_inc >= {1'b0, cfg.temp_period_frames}) ? 8'd0 : fc_inc[7:0];
				is_temp_n = 1'b0;
				shift_n   = '0;
				bit_n     = '0;
				do_enter  = 1'b1;
				ent       = ssp_pkg::PH_SEL_HI;
			end
		end else begin
			ignored = cmd;
			if (wait_q != 16'd0) begin
				wait_n = wait_q - 16'd1;
			end else begin
				do_enter = 1'b1;
				unique case (phase_q)
					ssp_pkg::PH_SEL_HI:  ent = ssp_pkg::PH_SEL_LO;
					ssp_pkg::PH_SEL_LO: begin
						bit_n = ADDR_LAST;
						ent   = ssp_pkg::PH_ADDR_LO;
					end
					ssp_pkg::PH_ADDR_LO: ent = ssp_pkg::PH_ADDR_HI;
					ssp_pkg::PH_ADDR_HI: begin
						if (bit_q == '0) begin
							ent = ssp_pkg::PH_TA_LO;
						end else begin
							bit_n = bit_q - IDX_W'(1);
							ent   = ssp_pkg::PH_ADDR_LO;
						end
					end
					ssp_pkg::PH_TA_LO:   ent = ssp_pkg::PH_TA_HI;
					ssp_pkg::PH_TA_HI:   ent = ssp_pkg::PH_TA_LO2;
					ssp_pkg::PH_TA_LO2: begin
						bit_n = DATA_LAST;
						ent   = ssp_pkg::PH_DAT_HI;
					end
					ssp_pkg::PH_DAT_HI:  ent = ssp_pkg::PH_DAT_LO;
					ssp_pkg::PH_DAT_LO: begin
						if (bit_q == '0) begin
							ent = ssp_pkg::PH_TAIL;
						end else begin
							bit_n = bit_q - IDX_W'(1);
							ent   = ssp_pkg::PH_DAT_HI;
						end
					end
					ssp_pkg::PH_TAIL: begin
						if (!is_temp_q && pend_q) begin
							// chain the temperature read, keep the error bits back
							hold_n    = shift_ext[1:0];
							pend_n    = 1'b0;
							is_temp_n = 1'b1;
							shift_n   = '0;
							bit_n     = '0;
							ent       = ssp_pkg::PH_SEL_HI;
						end else begin
							// publish and go idle
							if (is_temp_q) begin
								temp_n = shift_ext[7:0];
								err_n  = hold_q;
							end else begin
								err_n = shift_ext[1:0];
							end
							pend_n    = 1'b0;
							is_temp_n = 1'b0;
							upd       = 1'b1;
							do_enter  = 1'b0;
							phase_n   = ssp_pkg::PH_IDLE;
							wait_n    = 16'd0;
							bit_n     = '0;
							nss_n     = 1'b1;
							sck_n     = 1'b0;
							mosi_n    = 1'b0;
						end
					end
					default: ent = ssp_pkg::PH_IDLE;
				endcase
			end
		end

		// phase entry: reload the hold counter, set the pins and, entering PH_DAT_LO, capture miso
		if (do_enter) begin
			wait_n  = half_eff - 16'd1;
			phase_n = ent;
			unique case (ent)
				ssp_pkg::PH_SEL_HI: begin
					nss_n = 1'b1; sck_n = 1'b0; mosi_n = 1'b0;
				end
				ssp_pkg::PH_ADDR_LO: begin
					nss_n = 1'b0; sck_n = 1'b0;
					mosi_n = addr_word[bit_n[AIDX_W-1:0]];
				end
				ssp_pkg::PH_ADDR_HI: begin
					nss_n = 1'b0; sck_n = 1'b1;
				end
				ssp_pkg::PH_TA_HI, ssp_pkg::PH_DAT_HI: begin
					nss_n = 1'b0; sck_n = 1'b1; mosi_n = 1'b0;
				end
				ssp_pkg::PH_DAT_LO: begin
					nss_n = 1'b0; sck_n = 1'b0; mosi_n = 1'b0;
					shift_n[bit_n[DIDX_W-1:0]] = shift_q[bit_n[DIDX_W-1:0]] | miso;
				end
				ssp_pkg::PH_SEL_LO, ssp_pkg::PH_TA_LO, ssp_pkg::PH_TA_LO2,
				ssp_pkg::PH_TAIL: begin
					nss_n = 1'b0; sck_n = 1'b0; mosi_n = 1'b0;
				end
				default: begin
					phase_n = ssp_pkg::PH_IDLE;
					wait_n  = 16'd0;
					nss_n = 1'b1; sck_n = 1'b0; mosi_n = 1'b0;
				end
			endcase
		end
	end

	// sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ssp_pkg::PH_IDLE;
			bit_q     <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			fc_q      <= '0;
			temp_q    <= '0;
			err_q     <= '0;
			hold_q    <= '0;
			pend_q    <= 1'b0;
			is_temp_q <= 1'b0;
			nss_q     <= 1'b1;
			sck_q     <= 1'b0;
			mosi_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			bit_q     <= bit_n;
			wait_q    <= wait_n;
			shift_q   <= shift_n;
			fc_q      <= fc_n;
			temp_q    <= temp_n;
			err_q     <= err_n;
			hold_q    <= hold_n;
			pend_q    <= pend_n;
			is_temp_q <= is_temp_n;
			nss_q     <= nss_n;
			sck_q     <= sck_n;
			mosi_q    <= mosi_n;
		end
	end

	// result fields show the state after this tick
	always_comb begin
		res.nss             = nss_n;
		res.sck             = sck_n;
		res.mosi            = mosi_n;
		res.busy_res        = (phase_n != ssp_pkg::PH_IDLE);
		res.blackcal_error  = err_n;
		res.die_temperature = temp_n;
		res.status_update   = upd;
		res.frame_ignored   = ignored;
	end

endmodule

[rtl/ssp_outreg.sv]
`timescale 1ns / 1ps

module ssp_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  ssp_pkg::res_t  res,
	input  logic           take,
	output logic           room,
	output logic           valid,
	output ssp_pkg::res_t  data
);

	logic          valid_q;
	ssp_pkg::res_t data_q;

	// a new result may enter while the held one leaves
	assign room = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

[rtl/sensor_status_spi_poller.sv]
`timescale 1ns / 1ps
// Polls sensor status over a tick-driven SPI pin sequencer.
// Input stream: one transfer per tick; tuser carries the frame request flag,
// tdata bit 0 the miso level sampled on that tick.
// Output stream: one transfer per input transfer, in order, carrying the pin
// levels and status fields as they stand after that tick.
// Config channel: cfg_index 0 writes the SPI half period in ticks, 1 the
// number of frames between die temperature reads; always ready, write only
// while the stream is idle.
// Result: registered, valid in the cycle after its tick is taken.
// Throughput: one tick per cycle while the output receiver keeps tready high; the
// single sequencer register stage holds all pin and read state.
// Reset: chip select high, clock and data low, counters and status cleared,
// half period 50, temperature period 16; no result pending.
// Stall: while the output receiver holds tready low the held result stays and
// s_axis_tready drops, so no tick is taken and the sequencer does not advance.
module sensor_status_spi_poller #(
	parameter int ADDR_BITS = ssp_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = ssp_pkg::DATA_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] miso, [7:1] zero
	input  logic        s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] nss, [1] sck, [2] mosi, [3] busy_res, [5:4] blackcal_error,
	// [13:6] die_temperature, [14] status_update, [15] frame_ignored
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ssp_pkg::cfg_t cfg;
	ssp_pkg::res_t res, out_res;
	logic          step, room;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = room;
	assign step          = s_axis_tvalid && room;

	ssp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssp_seq #(
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (DATA_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (s_axis_tuser),
		.miso   (s_axis_tdata[0]),
		.cfg    (cfg),
		.res    (res)
	);

	ssp_outreg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.res    (res),
		.take   (m_axis_tready),
		.room   (room),
		.valid  (m_axis_tvalid),
		.data   (out_res)
	);

	// output field packing, highest bit first
	assign m_axis_tdata = {out_res.frame_ignored, out_res.status_update,
		out_res.die_temperature, out_res.blackcal_error, out_res.busy_res,
		out_res.mosi, out_res.sck, out_res.nss};

endmodule

[rtl/ssp_checker.sv]
`timescale 1ns / 1ps

module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [0:0]  cfg_index,
	input logic [15:0] cfg_data
);

	// held result does not change while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output result changed under stall");

	// input side takes a tick exactly when the result slot is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output slot");

	// an accepted tick gives a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick gave no result");

	// idle pins: select high, clock and data low
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[3] |->
		m_axis_tdata[0] && !m_axis_tdata[1] && !m_axis_tdata[2])
		else $error("pins active while idle");

	// status refresh only on the tick that ends the sequence
	a_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14] |-> !m_axis_tdata[3])
		else $error("status refreshed while busy");

endmodule

bind sensor_status_spi_poller ssp_checker u_ssp_checker (.*);
